/* design/rdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants and controller/datapath interface types for the range
// distinct-count unit.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // Array and value space sizes
    localparam int MAX_LENGTH  = 1024;
    localparam int VALUE_COUNT = 65536;

    // Field widths
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 16;
    localparam int LEN_W  = 11;
    localparam int CNT_W  = 11;
    localparam int FREQ_W = 12;
    localparam int SLOT_W = $clog2(VALUE_COUNT);

    // Item operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_en;   // write zero at the sweep address and advance it
        logic accept;     // input item taken this cycle
        logic init_rd;    // read element 0
        logic init_wr;    // seed window with element 0
        logic step_go;    // move one pointer by one position
        logic slot_cap;   // capture frequency slot of the element just read
        logic freq_upd;   // write updated frequency, adjust count
        logic out_load;   // load result register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last; // sweep is at its final entry
        logic started;    // window has been seeded
        logic step_done;  // query is bad or window already matches it
    } t_stat;

endpackage

/* design/rdc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rdc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ctrl
// Controller: sequences the frequency clear sweep, item intake, window seeding,
// the per-position pointer walk and result delivery.
// ----------------------------------------------------------------------------
module rdc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_op,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  rdc_pkg::t_stat i_stat,
    output rdc_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_INIT_WR,
        S_STEP,
        S_ELEM,
        S_FREQ,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_ready;

    // Next state and command decode
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == rdc_pkg::OP_QUERY) begin
                        n_state = i_stat.started ? S_STEP : S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_rd = 1'b1;
                n_state       = S_INIT_WR;
            end
            S_INIT_WR: begin
                o_cmd.init_wr = 1'b1;
                n_state       = S_STEP;
            end
            S_STEP: begin
                if (i_stat.step_done) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.step_go = 1'b1;
                    n_state       = S_ELEM;
                end
            end
            S_ELEM: begin
                o_cmd.slot_cap = 1'b1;
                n_state        = S_FREQ;
            end
            S_FREQ: begin
                o_cmd.freq_upd = 1'b1;
                n_state        = S_STEP;
            end
            S_RESULT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

/* design/rdc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_datapath
// Datapath: element store, frequency table, window pointers, distinct count,
// query latch, length register and result register.
// ----------------------------------------------------------------------------
module rdc_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rdc_pkg::t_cmd               i_cmd,
    output rdc_pkg::t_stat              o_stat,
    input  logic                        i_cfg_we,
    input  logic [rdc_pkg::LEN_W-1:0]   i_array_length,
    input  logic                        i_op,
    input  logic [rdc_pkg::IDX_W-1:0]   i_load_index,
    input  logic [rdc_pkg::VAL_W-1:0]   i_load_value,
    input  logic [rdc_pkg::IDX_W-1:0]   i_query_left,
    input  logic [rdc_pkg::IDX_W-1:0]   i_query_right,
    output logic [rdc_pkg::CNT_W-1:0]   o_distinct_count,
    output logic                        o_query_error
);

    localparam logic [rdc_pkg::LEN_W-1:0] LEN_MAX = rdc_pkg::LEN_W'(rdc_pkg::MAX_LENGTH);

    logic [rdc_pkg::LEN_W-1:0]         r_len;
    logic [rdc_pkg::IDX_W-1:0]         r_left, r_right;
    logic [rdc_pkg::IDX_W-1:0]         r_start, n_start;
    logic [rdc_pkg::IDX_W-1:0]         r_end, n_end;
    logic [rdc_pkg::CNT_W-1:0]         r_count;
    logic                              r_started;
    logic [rdc_pkg::SLOT_W-1:0]        r_clr_addr;
    logic [rdc_pkg::SLOT_W-1:0]        r_slot;
    logic                              r_add;
    logic [rdc_pkg::CNT_W-1:0]         r_out_count;
    logic                              r_out_err;

    logic [rdc_pkg::LEN_W-1:0]         w_len_eff;
    logic                              w_bad;
    logic                              w_end_dn, w_end_up, w_start_dn, w_start_up;
    logic [rdc_pkg::IDX_W-1:0]         w_pos;
    logic                              w_add;

    logic                              w_elem_we;
    logic [rdc_pkg::IDX_W-1:0]         w_elem_raddr;
    logic [rdc_pkg::VAL_W-1:0]         w_elem_rdata;
    logic [rdc_pkg::SLOT_W-1:0]        w_elem_slot;

    logic                              w_freq_we;
    logic [rdc_pkg::SLOT_W-1:0]        w_freq_waddr;
    logic signed [rdc_pkg::FREQ_W-1:0] w_freq_wdata;
    logic signed [rdc_pkg::FREQ_W-1:0] w_freq_rdata;
    logic signed [rdc_pkg::FREQ_W-1:0] w_freq_new;

    // Query check against the clamped length
    assign w_len_eff = (r_len > LEN_MAX) ? LEN_MAX : r_len;
    assign w_bad     = (r_left > r_right) || ({1'b0, r_right} >= w_len_eff);

    // Pick the next pointer move in fixed order: end down, end up, start down, start up
    assign w_end_dn   = r_end > r_right;
    assign w_end_up   = r_end < r_right;
    assign w_start_dn = r_start > r_left;
    assign w_start_up = r_start < r_left;

    always_comb begin
        n_start = r_start;
        n_end   = r_end;
        w_pos   = r_start;
        w_add   = 1'b0;
        if (w_end_dn) begin
            w_pos = r_end;
            n_end = r_end - 1'b1;
        end else if (w_end_up) begin
            n_end = r_end + 1'b1;
            w_pos = n_end;
            w_add = 1'b1;
        end else if (w_start_dn) begin
            n_start = r_start - 1'b1;
            w_pos   = n_start;
            w_add   = 1'b1;
        end else if (w_start_up) begin
            n_start = r_start + 1'b1;
        end
    end

    // Element store: loads before the first query, reads for the walk
    assign w_elem_we    = i_cmd.accept && (i_op == rdc_pkg::OP_LOAD) && !r_started;
    assign w_elem_raddr = i_cmd.init_rd ? '0 : w_pos;
    assign w_elem_slot  = rdc_pkg::SLOT_W'(w_elem_rdata);

    rdc_ram #(
        .WIDTH (rdc_pkg::VAL_W),
        .DEPTH (rdc_pkg::MAX_LENGTH)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (w_elem_we),
        .i_waddr (i_load_index),
        .i_wdata (i_load_value),
        .i_raddr (w_elem_raddr),
        .o_rdata (w_elem_rdata)
    );

    // Frequency table: clear sweep, seed, or read-modify-write
    assign w_freq_new = r_add ? (w_freq_rdata + rdc_pkg::FREQ_W'(1))
                              : (w_freq_rdata - rdc_pkg::FREQ_W'(1));

    always_comb begin
        w_freq_we    = 1'b0;
        w_freq_waddr = r_slot;
        w_freq_wdata = w_freq_new;
        if (i_cmd.clear_en) begin
            w_freq_we    = 1'b1;
            w_freq_waddr = r_clr_addr;
            w_freq_wdata = '0;
        end else if (i_cmd.init_wr) begin
            w_freq_we    = 1'b1;
            w_freq_waddr = w_elem_slot;
            w_freq_wdata = rdc_pkg::FREQ_W'(1);
        end else if (i_cmd.freq_upd) begin
            w_freq_we    = 1'b1;
        end
    end

    rdc_ram #(
        .WIDTH (rdc_pkg::FREQ_W),
        .DEPTH (rdc_pkg::VALUE_COUNT)
    ) u_freq_ram (
        .i_clk   (i_clk),
        .i_we    (w_freq_we),
        .i_waddr (w_freq_waddr),
        .i_wdata (w_freq_wdata),
        .i_raddr (w_elem_slot),
        .o_rdata (w_freq_rdata)
    );

    // Control registers: length, window, count, seed flag, sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= rdc_pkg::LEN_W'(1);
            r_start    <= '0;
            r_end      <= '0;
            r_count    <= rdc_pkg::CNT_W'(1);
            r_started  <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_array_length;
            end
            if (i_cmd.clear_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.init_wr) begin
                r_started <= 1'b1;
                r_count   <= rdc_pkg::CNT_W'(1);
            end
            if (i_cmd.step_go) begin
                r_start <= n_start;
                r_end   <= n_end;
            end
            if (i_cmd.freq_upd) begin
                if (r_add && (w_freq_new == rdc_pkg::FREQ_W'(1))) begin
                    r_count <= r_count + 1'b1;
                end else if (!r_add && (w_freq_new == '0)) begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    // Payload registers: query bounds, step slot and direction, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_left  <= i_query_left;
            r_right <= i_query_right;
        end
        if (i_cmd.step_go) begin
            r_add <= w_add;
        end
        if (i_cmd.slot_cap) begin
            r_slot <= w_elem_slot;
        end
        if (i_cmd.out_load) begin
            r_out_count <= w_bad ? '0 : r_count;
            r_out_err   <= w_bad;
        end
    end

    assign o_stat.clear_last = (r_clr_addr == {rdc_pkg::SLOT_W{1'b1}});
    assign o_stat.started    = r_started;
    assign o_stat.step_done  = w_bad || !(w_end_dn || w_end_up || w_start_dn || w_start_up);

    assign o_distinct_count = r_out_count;
    assign o_query_error    = r_out_err;

endmodule

/* design/range_distinct_count_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_distinct_count_unit
// Counts distinct values in a queried index range of a loaded array by sliding
// a window one position at a time over a per-value frequency table.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_ready         i_op, i_load_index, i_load_value,
//                                                 i_query_left, i_query_right
//  result    out        o_valid / i_ready         o_distinct_count, o_query_error
//  config    in         i_cfg_valid / o_cfg_ready i_array_length
//
//  After reset the frequency table is cleared one entry a cycle, all 65536
//  entries, with o_ready low; configuration writes are taken throughout.
//  A load leaves o_ready high. A taken query drops o_ready while the window
//  pointers move one position at a time (element read, frequency read,
//  frequency write for each move); its result is valid as o_ready rises again.
//  The first query also seeds the window with element 0 before the walk.
//  One item is worked on at a time; a finished result waits in the output
//  register and the next item is taken while it waits. A later query result
//  holds the controller until the waiting one is taken.
// ----------------------------------------------------------------------------
module range_distinct_count_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic [rdc_pkg::IDX_W-1:0] i_load_index,
    input  logic [rdc_pkg::VAL_W-1:0] i_load_value,
    input  logic [rdc_pkg::IDX_W-1:0] i_query_left,
    input  logic [rdc_pkg::IDX_W-1:0] i_query_right,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [rdc_pkg::CNT_W-1:0] o_distinct_count,
    output logic                      o_query_error,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [rdc_pkg::LEN_W-1:0] i_array_length
);

    rdc_pkg::t_cmd  w_cmd;
    rdc_pkg::t_stat w_stat;

    // Length register is always writable
    assign o_cfg_ready = 1'b1;

    rdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    rdc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_array_length   (i_array_length),
        .i_op             (i_op),
        .i_load_index     (i_load_index),
        .i_load_value     (i_load_value),
        .i_query_left     (i_query_left),
        .i_query_right    (i_query_right),
        .o_distinct_count (o_distinct_count),
        .o_query_error    (o_query_error)
    );

    // An error result always reports a zero count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_query_error) |-> (o_distinct_count == '0))
        else $error("error result with nonzero count");

    // A taken query keeps the input closed on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_op == rdc_pkg::OP_QUERY)) |=> !o_ready)
        else $error("input reopened right after a query");

    // Once seeded, the window stays seeded until reset
    a_started_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> !$fell(w_stat.started))
        else $error("window seed flag dropped");

    // No item is taken during the clear sweep or while a query is in progress
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.clear_en || w_cmd.step_go || w_cmd.freq_upd) |-> !o_ready)
        else $error("input open while busy");

endmodule
